@@ rtl/pef_pkg.sv @@
// Shared constants, codes and types of the edge-fill polygon rasterizer.
package pef_pkg;

    // Default geometry and storage width
    localparam int FRAME_WIDTH_DEF  = 256;
    localparam int FRAME_HEIGHT_DEF = 256;
    localparam int COLOUR_BITS_DEF  = 24;

    // Fixed field widths of the stream items
    localparam int COORD_W    = 8;
    localparam int COLOUR_W   = 24;
    localparam int BOUND_W    = 9;
    localparam int COUNT_W    = 17;
    localparam int IN_DATA_W  = 56;
    localparam int OUT_DATA_W = 48;

    // Edge accumulator is unsigned Q8.16
    localparam int                  XACC_BITS = 24;
    localparam logic [XACC_BITS:0]  HALF_Q16  = 25'h008000;
    localparam logic [COUNT_W-1:0]  COUNT_MAX = 17'h1FFFF;

    // Action codes carried in tuser
    localparam logic [1:0] ACT_FILL  = 2'd0;
    localparam logic [1:0] ACT_READ  = 2'd1;
    localparam logic [1:0] ACT_WRITE = 2'd2;

    // Configuration register indexes
    localparam logic [1:0] CFG_FILL  = 2'd0;
    localparam logic [1:0] CFG_BACK  = 2'd1;
    localparam logic [1:0] CFG_BOUND = 2'd2;

    localparam logic [COLOUR_W-1:0] FILL_RESET  = 24'h000000;
    localparam logic [COLOUR_W-1:0] BACK_RESET  = 24'hFFFFFF;
    localparam logic [BOUND_W-1:0]  BOUND_RESET = 9'd256;

    // Request to the slope divider
    typedef struct packed {
        logic                 start;
        logic                 neg;
        logic [XACC_BITS-1:0] num;
        logic [COORD_W-1:0]   den;
    } div_req_t;

endpackage

@@ rtl/pef_div.sv @@
// Restoring divider producing the signed Q16 edge slope, one quotient bit per cycle.
module pef_div
    import pef_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  div_req_t             req,
    output logic                 done,
    output logic [XACC_BITS-1:0] quot
);

    localparam int CNT_W = $clog2(XACC_BITS);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(XACC_BITS - 1);

    logic                 run_reg;
    logic                 done_reg;
    logic [CNT_W-1:0]     cnt_reg;
    logic [XACC_BITS-1:0] num_reg;
    logic [COORD_W-1:0]   rem_reg;
    logic [COORD_W-1:0]   den_reg;
    logic                 neg_reg;

    logic [COORD_W:0]     rem_sh;
    logic                 ge;
    logic [COORD_W:0]     rem_sub;

    assign rem_sh  = {rem_reg, num_reg[XACC_BITS-1]};
    assign ge      = rem_sh >= {1'b0, den_reg};
    assign rem_sub = rem_sh - {1'b0, den_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                run_reg <= 1'b1;
                cnt_reg <= '0;
            end
            else if (run_reg)
            begin
                if (cnt_reg == CNT_LAST)
                begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
                else
                begin
                    cnt_reg <= cnt_reg + 1'b1;
                end
            end
        end
    end

    // Quotient bits shift in from the bottom as the dividend shifts out of the top
    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            num_reg <= req.num;
            den_reg <= req.den;
            neg_reg <= req.neg;
            rem_reg <= '0;
        end
        else if (run_reg)
        begin
            num_reg <= {num_reg[XACC_BITS-2:0], ge};
            rem_reg <= ge ? rem_sub[COORD_W-1:0] : rem_sh[COORD_W-1:0];
        end
    end

    assign done = done_reg;
    assign quot = neg_reg ? (~num_reg + 1'b1) : num_reg;

endmodule

@@ rtl/polygon_edge_fill_rasterizer.sv @@
// Edge-fill polygon rasterizer: frame store with read-modify-write complement spans.
//
//  channel   direction  handshake                      contents
//  s_axis    in         s_axis_tvalid / s_axis_tready  action in tuser, endpoints, colour
//  m_axis    out        m_axis_tvalid / m_axis_tready  read colour, pixels touched
//  cfg       in         cfg_valid / cfg_ready          register index, data
//
//  A write or a read of one pixel is dispatched directly; a horizontal edge touches nothing.
//  Any other fill waits on the slope divider, then walks its scanlines, complementing each
//  pixel of a span, and finishes; the one-read one-write frame store port pair lets the
//  read of each pixel overlap the write of the pixel before it.
//  One item is in work at a time; the next item is taken while a result waits.
//  Reset clears control and configuration; the frame store holds no reset value.
module polygon_edge_fill_rasterizer
    import pef_pkg::*;
#(
    parameter int FRAME_WIDTH  = FRAME_WIDTH_DEF,
    parameter int FRAME_HEIGHT = FRAME_HEIGHT_DEF,
    parameter int COLOUR_BITS  = COLOUR_BITS_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // x_a[7:0], y_a[15:8], x_b[23:16], y_b[31:24], write_colour[55:32]
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,
    // action[1:0]
    input  logic [1:0]            s_axis_tuser,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // read_colour[23:0], pixels_touched[40:24], zero above
    output logic [OUT_DATA_W-1:0] m_axis_tdata,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [1:0]            cfg_index,
    input  logic [COLOUR_W-1:0]   cfg_data
);

    localparam int DEPTH  = FRAME_WIDTH * FRAME_HEIGHT;
    localparam int ADDR_W = $clog2(DEPTH);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_DISP  = 3'd1;
    localparam logic [2:0] S_RDATA = 3'd2;
    localparam logic [2:0] S_DIV   = 3'd3;
    localparam logic [2:0] S_ROW   = 3'd4;
    localparam logic [2:0] S_SPAN  = 3'd5;
    localparam logic [2:0] S_FIN   = 3'd6;

    function automatic logic [ADDR_W-1:0] pix_addr(input logic [COORD_W-1:0] y,
                                                   input logic [BOUND_W-1:0] x);
        pix_addr = ADDR_W'(y) * ADDR_W'(FRAME_WIDTH) + ADDR_W'(x);
    endfunction

    // Configuration
    logic [COLOUR_W-1:0] fill_reg, back_reg;
    logic [BOUND_W-1:0]  bound_reg;

    // Item fields
    logic [1:0]          act_reg;
    logic [COORD_W-1:0]  xa_reg, ya_reg, xb_reg, yb_reg;
    logic [COLOUR_W-1:0] wc_reg;

    // Control and edge walk
    logic [2:0]            state_reg, state_next;
    logic [COORD_W-1:0]    y_reg, y_next;
    logic [COORD_W-1:0]    yhi_reg, yhi_next;
    logic [XACC_BITS-1:0]  xacc_reg, xacc_next;
    logic [XACC_BITS-1:0]  slope_reg, slope_next;
    logic [BOUND_W-1:0]    x_reg, x_next;
    logic                  pend_reg, pend_next;
    logic [ADDR_W-1:0]     pend_addr_reg, pend_addr_next;
    logic [COUNT_W-1:0]    count_reg, count_next;
    logic [COLOUR_W-1:0]   res_colour_reg, res_colour_next;
    logic                  out_valid_reg, out_valid_next;
    logic [OUT_DATA_W-1:0] out_data_reg, out_data_next;

    // Frame store
    logic [COLOUR_BITS-1:0] mem [DEPTH];
    logic [COLOUR_BITS-1:0] rd_data_reg;
    logic                   rd_en;
    logic [ADDR_W-1:0]      rd_addr;
    logic                   wr_en;
    logic [ADDR_W-1:0]      wr_addr;
    logic [COLOUR_BITS-1:0] wr_data;

    div_req_t             div_req;
    logic                 div_done;
    logic [XACC_BITS-1:0] div_quot;

    logic                 in_acc;
    logic                 pix_inside;
    logic                 row_inside;
    logic [BOUND_W-1:0]   xend;
    logic [XACC_BITS:0]   xacc_round;
    logic [BOUND_W-1:0]   span_start;
    logic [COLOUR_BITS-1:0] fill_c, back_c;
    logic [COLOUR_BITS-1:0] flip_data;
    logic [COORD_W-1:0]   dx_mag;

    pef_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .done  (div_done),
        .quot  (div_quot)
    );

    assign s_axis_tready = (state_reg == S_IDLE);
    assign in_acc        = s_axis_tvalid && s_axis_tready;
    assign cfg_ready     = 1'b1;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    assign pix_inside = (32'(xa_reg) < FRAME_WIDTH) && (32'(ya_reg) < FRAME_HEIGHT);
    assign row_inside = 32'(y_reg) < FRAME_HEIGHT;
    assign xend       = (32'(bound_reg) < FRAME_WIDTH) ? bound_reg : BOUND_W'(FRAME_WIDTH);
    assign xacc_round = {1'b0, xacc_reg} + HALF_Q16;
    assign span_start = xacc_round[XACC_BITS:XACC_BITS-BOUND_W+1];
    assign fill_c     = COLOUR_BITS'(fill_reg);
    assign back_c     = COLOUR_BITS'(back_reg);
    assign flip_data  = (rd_data_reg == fill_c) ? back_c : fill_c;
    assign dx_mag     = (xa_reg >= xb_reg) ? (xa_reg - xb_reg) : (xb_reg - xa_reg);

    always_comb
    begin
        state_next      = state_reg;
        y_next          = y_reg;
        yhi_next        = yhi_reg;
        xacc_next       = xacc_reg;
        slope_next      = slope_reg;
        x_next          = x_reg;
        pend_next       = 1'b0;
        pend_addr_next  = pend_addr_reg;
        count_next      = count_reg;
        res_colour_next = res_colour_reg;
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        rd_en           = 1'b0;
        rd_addr         = pix_addr(ya_reg, BOUND_W'(xa_reg));
        wr_en           = pend_reg;
        wr_addr         = pend_addr_reg;
        wr_data         = flip_data;
        div_req         = '0;

        // Complete the write half of the previous pixel
        if (pend_reg && count_reg != COUNT_MAX)
        begin
            count_next = count_reg + 1'b1;
        end

        if (out_valid_reg && m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (in_acc)
                begin
                    state_next = S_DISP;
                end
            end
            S_DISP:
            begin
                count_next      = '0;
                res_colour_next = '0;
                state_next      = S_FIN;
                case (act_reg)
                    ACT_FILL:
                    begin
                        if (ya_reg != yb_reg)
                        begin
                            if (ya_reg < yb_reg)
                            begin
                                y_next    = ya_reg;
                                yhi_next  = yb_reg;
                                xacc_next = {xa_reg, 16'h0000};
                            end
                            else
                            begin
                                y_next    = yb_reg;
                                yhi_next  = ya_reg;
                                xacc_next = {xb_reg, 16'h0000};
                            end
                            div_req.start = 1'b1;
                            div_req.neg   = (xa_reg < xb_reg) != (ya_reg < yb_reg);
                            div_req.num   = {dx_mag, 16'h0000};
                            div_req.den   = (ya_reg > yb_reg) ? (ya_reg - yb_reg)
                                                              : (yb_reg - ya_reg);
                            state_next    = S_DIV;
                        end
                    end
                    ACT_READ:
                    begin
                        if (pix_inside)
                        begin
                            rd_en      = 1'b1;
                            state_next = S_RDATA;
                        end
                    end
                    ACT_WRITE:
                    begin
                        if (pix_inside)
                        begin
                            wr_en   = 1'b1;
                            wr_addr = pix_addr(ya_reg, BOUND_W'(xa_reg));
                            wr_data = COLOUR_BITS'(wc_reg);
                        end
                    end
                    default:
                    begin
                        state_next = S_FIN;
                    end
                endcase
            end
            S_RDATA:
            begin
                res_colour_next = COLOUR_W'(rd_data_reg);
                state_next      = S_FIN;
            end
            S_DIV:
            begin
                if (div_done)
                begin
                    slope_next = div_quot;
                    state_next = S_ROW;
                end
            end
            S_ROW:
            begin
                if (y_reg == yhi_reg)
                begin
                    state_next = S_FIN;
                end
                else if (row_inside && span_start < xend)
                begin
                    x_next     = span_start;
                    state_next = S_SPAN;
                end
                else
                begin
                    xacc_next = xacc_reg + slope_reg;
                    y_next    = y_reg + 1'b1;
                end
            end
            S_SPAN:
            begin
                // Read this pixel; its write follows in the next cycle
                rd_en          = 1'b1;
                rd_addr        = pix_addr(y_reg, x_reg);
                pend_next      = 1'b1;
                pend_addr_next = pix_addr(y_reg, x_reg);
                if (x_reg == xend - 1'b1)
                begin
                    xacc_next  = xacc_reg + slope_reg;
                    y_next     = y_reg + 1'b1;
                    state_next = S_ROW;
                end
                else
                begin
                    x_next = x_reg + 1'b1;
                end
            end
            S_FIN:
            begin
                if (!out_valid_reg || m_axis_tready)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = {{(OUT_DATA_W - COUNT_W - COLOUR_W){1'b0}},
                                      count_reg, res_colour_reg};
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
            fill_reg      <= FILL_RESET;
            back_reg      <= BACK_RESET;
            bound_reg     <= BOUND_RESET;
        end
        else
        begin
            state_reg     <= state_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_FILL:  fill_reg  <= cfg_data;
                    CFG_BACK:  back_reg  <= cfg_data;
                    CFG_BOUND: bound_reg <= cfg_data[BOUND_W-1:0];
                    default:   ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            act_reg <= s_axis_tuser;
            xa_reg  <= s_axis_tdata[7:0];
            ya_reg  <= s_axis_tdata[15:8];
            xb_reg  <= s_axis_tdata[23:16];
            yb_reg  <= s_axis_tdata[31:24];
            wc_reg  <= s_axis_tdata[55:32];
        end
        y_reg          <= y_next;
        yhi_reg        <= yhi_next;
        xacc_reg       <= xacc_next;
        slope_reg      <= slope_next;
        x_reg          <= x_next;
        pend_addr_reg  <= pend_addr_next;
        count_reg      <= count_next;
        res_colour_reg <= res_colour_next;
        out_data_reg   <= out_data_next;
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

endmodule

@@ rtl/pef_checker.sv @@
// Port-level checks of the rasterizer, bound to the top level.
module pef_checker
    import pef_pkg::*;
(
    input logic                  clk,
    input logic                  rst_n,
    input logic                  s_axis_tvalid,
    input logic                  s_axis_tready,
    input logic                  m_axis_tvalid,
    input logic                  m_axis_tready,
    input logic [OUT_DATA_W-1:0] m_axis_tdata
);

    // Hold a stalled result unchanged
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed or dropped while stalled");

    // One item in work: input closes right after an accept
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input still open after an item was taken");

    // A fill result never carries a read colour
    a_fill_no_colour: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && (m_axis_tdata[COLOUR_W +: COUNT_W] != '0)
        |-> m_axis_tdata[COLOUR_W-1:0] == '0)
        else $error("fill result with non-zero read colour");

    a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tdata[OUT_DATA_W-1:COLOUR_W+COUNT_W] == '0)
        else $error("result padding not zero");

endmodule

bind polygon_edge_fill_rasterizer pef_checker u_pef_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
